[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/lcd4_pkg.sv]
// ----------------------------------------------------------------------------
// lcd4_pkg
// Types and constants for the 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

    localparam int CFG_W      = 16;
    localparam int SHIFT_W    = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int UNIT_W     = 18;   // sum of three 16-bit waits
    localparam int TICK_W     = 22;
    localparam int STEP_W     = 6;

    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_WAIT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BYTE_WAIT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WAKE_WAIT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INIT_GAP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_SHIFT = 3'd4;

    localparam logic [CFG_W-1:0]   RST_PULSE_WAIT  = 16'd2000;
    localparam logic [CFG_W-1:0]   RST_BYTE_WAIT   = 16'd10000;
    localparam logic [CFG_W-1:0]   RST_WAKE_WAIT   = 16'd15000;
    localparam logic [CFG_W-1:0]   RST_INIT_GAP    = 16'd20000;
    localparam logic [SHIFT_W-1:0] RST_DELAY_SHIFT = 3'd0;

    // step numbering
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 6'd32;
    localparam logic [STEP_W-1:0] INIT_CMD_STEP   = 6'd9;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 6'd3;

    localparam logic [3:0] WAKE_NIBBLE = 4'h3;
    localparam logic [3:0] FUNC_NIBBLE = 4'h2;
    localparam logic [7:0] LINE1_ADDR  = 8'h80;
    localparam logic [7:0] LINE2_ADDR  = 8'hC0;
    localparam logic [1:0] ROW_FIRST   = 2'd1;
    localparam logic [2:0] INIT_CMD_LAST = 3'd5;

    // job queue
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_INIT = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_DATA = 2'd2,
        KIND_POS  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic [5:0]  column;
        logic [1:0]  row;
    } lcd4_in_t;

    typedef struct packed {
        logic              reg_select;
        logic [3:0]        data_nibble;
        logic              enable;
        logic [TICK_W-1:0] hold_ticks;
        logic              last;
    } lcd4_out_t;

    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] byte_val;
    } lcd4_job_t;

    typedef struct packed {
        logic [CFG_W-1:0]   pulse_wait;
        logic [CFG_W-1:0]   byte_wait;
        logic [CFG_W-1:0]   wake_wait;
        logic [CFG_W-1:0]   init_gap;
        logic [SHIFT_W-1:0] delay_shift;   // already clamped
    } lcd4_cfg_t;

    // init command list
    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h28;
                3'd1:    c = 8'h08;
                3'd2:    c = 8'h01;
                3'd3:    c = 8'h06;
                3'd4:    c = 8'h0C;
                default: c = 8'h01;
            endcase
            return c;
        end
    endfunction

endpackage

[design/lcd4_front.sv]
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts request words and turns them into sequencer jobs.
// ----------------------------------------------------------------------------
module lcd4_front (
    input  logic                push,
    output logic                full,
    input  lcd4_pkg::lcd4_in_t  in_word,
    output logic                job_push,
    output lcd4_pkg::lcd4_job_t job,
    input  logic                job_full
);
    import lcd4_pkg::*;

    logic [7:0] pos_base;

    assign full     = job_full;
    assign job_push = push && !job_full;

    // any row other than the first selects line two
    assign pos_base = (in_word.row == ROW_FIRST) ? LINE1_ADDR : LINE2_ADDR;

    always_comb
    begin
        job.is_init    = (in_word.kind == KIND_INIT);
        job.reg_select = (in_word.kind == KIND_DATA);
        unique case (in_word.kind)
            KIND_CMD,
            KIND_DATA: job.byte_val = in_word.byte_value;
            KIND_POS:  job.byte_val = pos_base - 8'd1 + {2'b00, in_word.column};
            default:   job.byte_val = 8'h00;
        endcase
    end

endmodule

[design/lcd4_fifo.sv]
// ----------------------------------------------------------------------------
// lcd4_fifo
// Short job queue between the front and the step sequencer.
// ----------------------------------------------------------------------------
module lcd4_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  lcd4_pkg::lcd4_job_t wr_data,
    output logic                full,
    input  logic                rd,
    output lcd4_pkg::lcd4_job_t rd_data,
    output logic                empty
);
    import lcd4_pkg::*;

    lcd4_job_t             mem_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0]  count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full    = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/lcd4_back.sv]
// ----------------------------------------------------------------------------
// lcd4_back
// Step sequencer: expands one job into pin steps, one per cycle while pop keeps the output moving.
// ----------------------------------------------------------------------------
module lcd4_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lcd4_pkg::lcd4_cfg_t cfg,
    input  logic                job_valid,
    input  lcd4_pkg::lcd4_job_t job_in,
    output logic                job_pop,
    output logic                empty,
    input  logic                pop,
    output lcd4_pkg::lcd4_out_t out_word
);
    import lcd4_pkg::*;

    logic                busy_reg, busy_next;
    lcd4_job_t           job_reg, job_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    lcd4_out_t           out_reg, out_next;

    logic                advance;
    logic                step_last;
    logic [STEP_W-1:0]   s1, s9;
    logic [2:0]          cmd_idx;
    logic [7:0]          cur_byte;
    logic [1:0]          phase;
    logic [UNIT_W-1:0]   units;
    logic [UNIT_W-1:0]   extra;
    lcd4_out_t           step_word;

    assign advance = !out_valid_reg || pop;
    assign empty   = !out_valid_reg;
    assign out_word = out_reg;

    assign s1      = step_reg - 6'd1;
    assign s9      = step_reg - INIT_CMD_STEP;
    assign cmd_idx = s9[4:2];
    assign cur_byte = job_reg.is_init ? init_cmd(cmd_idx) : job_reg.byte_val;
    assign phase    = job_reg.is_init ? s9[1:0] : step_reg[1:0];
    assign step_last = job_reg.is_init ? (step_reg == INIT_LAST_STEP)
                                       : (step_reg == BYTE_LAST_STEP);

    // init gap follows every init command but the last
    assign extra = (job_reg.is_init && cmd_idx != INIT_CMD_LAST)
                 ? UNIT_W'(cfg.init_gap) : '0;

    // decode the current step
    always_comb
    begin
        step_word            = '0;
        step_word.reg_select = job_reg.reg_select;
        units                = '0;
        if (job_reg.is_init && step_reg == '0)
        begin
            // power-up wait, pins low
            step_word.data_nibble = 4'h0;
            step_word.enable      = 1'b0;
            units                 = UNIT_W'(cfg.wake_wait);
        end
        else if (job_reg.is_init && step_reg < INIT_CMD_STEP)
        begin
            // wake nibbles 3,3,3 then 2
            step_word.data_nibble = (s1[5:1] == 5'd3) ? FUNC_NIBBLE : WAKE_NIBBLE;
            step_word.enable      = !s1[0];
            units                 = UNIT_W'(cfg.pulse_wait);
            if (s1[0] && s1[5:1] < 5'd2)
            begin
                units = UNIT_W'(cfg.pulse_wait) + UNIT_W'(cfg.wake_wait);
            end
        end
        else
        begin
            step_word.data_nibble = phase[1] ? cur_byte[3:0] : cur_byte[7:4];
            step_word.enable      = !phase[0];
            units                 = UNIT_W'(cfg.pulse_wait);
            if (phase == 2'd3)
            begin
                units = UNIT_W'(cfg.pulse_wait) + UNIT_W'(cfg.byte_wait) + extra;
            end
        end
        step_word.hold_ticks = TICK_W'(TICK_W'(units) << cfg.delay_shift);
        step_word.last       = step_last;
    end

    assign job_pop = job_valid && (!busy_reg || (advance && step_last));

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                out_next  = step_word;
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        if (job_pop)
        begin
            job_next  = job_in;
            step_next = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

endmodule

[design/char_lcd_4bit_write_sequencer_top.sv]
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_top
// Character LCD 4-bit write sequencer: requests in, timed pin steps out.
// ----------------------------------------------------------------------------
// Path: push -> job queue -> job register -> output register -> out_word.
// Throughput: one step word per cycle while pop keeps up, so 4 step words
//   per byte request and 33 for init; a bubble appears only when the
//   sequencer had gone idle before the next job arrived.
// Reset: clears the job queue and output stage, loads default waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_4bit_write_sequencer_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request side
    input  logic                                  push,
    output logic                                  full,
    input  lcd4_pkg::lcd4_in_t                    in_word,
    // step side
    output logic                                  empty,
    input  logic                                  pop,
    output lcd4_pkg::lcd4_out_t                   out_word,
    // register writes
    input  logic                                  cfg_we,
    input  logic [lcd4_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lcd4_pkg::CFG_W-1:0]            cfg_data
);
    import lcd4_pkg::*;

    // Register file. The user must make writes only while idle; the block does
    // not enforce this, and the sequencer reads these live.
    logic [CFG_W-1:0]   pulse_wait_reg;
    logic [CFG_W-1:0]   byte_wait_reg;
    logic [CFG_W-1:0]   wake_wait_reg;
    logic [CFG_W-1:0]   init_gap_reg;
    logic [SHIFT_W-1:0] delay_shift_reg;
    lcd4_cfg_t          cfg;

    // front -> queue -> back
    logic      front_push;
    lcd4_job_t front_job;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    lcd4_job_t q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_wait_reg  <= RST_PULSE_WAIT;
            byte_wait_reg   <= RST_BYTE_WAIT;
            wake_wait_reg   <= RST_WAKE_WAIT;
            init_gap_reg    <= RST_INIT_GAP;
            delay_shift_reg <= RST_DELAY_SHIFT;
        end
        else if (cfg_we)
        begin
            // unknown indexes fall through and are dropped
            unique case (cfg_addr)
                REG_PULSE_WAIT:  pulse_wait_reg  <= cfg_data;
                REG_BYTE_WAIT:   byte_wait_reg   <= cfg_data;
                REG_WAKE_WAIT:   wake_wait_reg   <= cfg_data;
                REG_INIT_GAP:    init_gap_reg    <= cfg_data;
                REG_DELAY_SHIFT: delay_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end
    end

    // shift above the max saturates
    always_comb
    begin
        cfg.pulse_wait  = pulse_wait_reg;
        cfg.byte_wait   = byte_wait_reg;
        cfg.wake_wait   = wake_wait_reg;
        cfg.init_gap    = init_gap_reg;
        cfg.delay_shift = (delay_shift_reg > MAX_SHIFT) ? MAX_SHIFT : delay_shift_reg;
    end

    // Front: classify the request word, build the command byte.
    lcd4_front u_front (
        .push     (push),
        .full     (full),
        .in_word  (in_word),
        .job_push (front_push),
        .job      (front_job),
        .job_full (q_full)
    );

    // Short queue so the front keeps taking words while steps drain.
    lcd4_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (front_push),
        .wr_data (front_job),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (q_job),
        .empty   (q_empty)
    );

    // Back: one step per cycle while pop keeps up, into a registered output word.
    lcd4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (!q_empty),
        .job_in    (q_job),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

    // The final step of any request always drops enable.
    `ASSERT_IMPL(a_last_enable_low, clk, rst_n, !empty && out_word.last, !out_word.enable)

    // An enable-high step holds exactly the scaled pulse width.
    `ASSERT_IMPL(a_high_pulse_width, clk, rst_n, !empty && out_word.enable, out_word.hold_ticks == (TICK_W'(pulse_wait_reg) << cfg.delay_shift))

    // Enable-low step of the same nibble follows right after the high step.
    `ASSERT_NEXT(a_low_follows_high, clk, rst_n, !empty && pop && out_word.enable, !empty && !out_word.enable)

    // Queue never drops a job the front accepted.
    `ASSERT_IMPL(a_no_push_when_full, clk, rst_n, q_full, !front_push)

endmodule
